@@ rtl/core/aseu_pkg.sv @@
// ----------------------------------------------------------------------------
// aseu_pkg: shared definitions of the execute unit
// Widths, operation and address mode codes, compare flag codes and the
// register file write port type.
// ----------------------------------------------------------------------------
`default_nettype none

package aseu_pkg;

    localparam int DATA_W        = 32;
    localparam int RF_AW         = 4;
    localparam int RF_DEPTH      = 16;
    localparam int MEM_WORDS_DEF = 128;
    localparam int BASE_W        = 16;
    localparam int TARGET_W      = 10;

    localparam logic [BASE_W-1:0] DATA_BASE_RST = 16'd1000;

    localparam logic [RF_AW-1:0] REG_LINK = 4'd14;
    localparam logic [RF_AW-1:0] REG_PC   = 4'd15;

    localparam logic [3:0] OP_MOV  = 4'd0;
    localparam logic [3:0] OP_CMP  = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_SUB  = 4'd3;
    localparam logic [3:0] OP_MUL  = 4'd4;
    localparam logic [3:0] OP_LDR  = 4'd5;
    localparam logic [3:0] OP_STR  = 4'd6;
    localparam logic [3:0] OP_LDRL = 4'd7;
    localparam logic [3:0] OP_B    = 4'd8;
    localparam logic [3:0] OP_BNE  = 4'd9;
    localparam logic [3:0] OP_BGE  = 4'd10;
    localparam logic [3:0] OP_BL   = 4'd11;
    localparam logic [3:0] OP_EXIT = 4'd12;

    localparam logic [1:0] AMODE_BASE = 2'd0;
    localparam logic [1:0] AMODE_POST = 2'd1;
    localparam logic [1:0] AMODE_OFFS = 2'd2;

    localparam logic [1:0] FLAG_EQ = 2'd0;
    localparam logic [1:0] FLAG_GT = 2'd1;
    localparam logic [1:0] FLAG_LT = 2'd2;

    typedef struct packed {
        logic              we;
        logic [RF_AW-1:0]  addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/aseu_regfile.sv @@
// ----------------------------------------------------------------------------
// aseu_regfile: register file with two registered read ports
// Sixteen words with one write port. A write at the same edge as a read of
// the same entry is forwarded, and an entry never written reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aseu_regfile
    import aseu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rf_wr_t            wr,
    input  wire logic              rd_en,
    input  wire logic [RF_AW-1:0]  rd_addr_x,
    input  wire logic [RF_AW-1:0]  rd_addr_y,
    output logic      [DATA_W-1:0] rd_data_x,
    output logic      [DATA_W-1:0] rd_data_y
);

    logic [DATA_W-1:0]   mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]   rd_data_x_reg;
    logic [DATA_W-1:0]   rd_data_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            if (wr.we && (wr.addr == rd_addr_x))
            begin
                rd_data_x_reg <= wr.data;
            end
            else
            begin
                rd_data_x_reg <= valid_reg[rd_addr_x] ? mem[rd_addr_x] : '0;
            end
            if (wr.we && (wr.addr == rd_addr_y))
            begin
                rd_data_y_reg <= wr.data;
            end
            else
            begin
                rd_data_y_reg <= valid_reg[rd_addr_y] ? mem[rd_addr_y] : '0;
            end
        end
    end

    assign rd_data_x = rd_data_x_reg;
    assign rd_data_y = rd_data_y_reg;

endmodule

`default_nettype wire

@@ rtl/core/arm_subset_execute_unit_top.sv @@
// ----------------------------------------------------------------------------
// arm_subset_execute_unit_top: execute unit for a small ARM-like subset
// Executes one decoded instruction per input item and returns one result
// item holding r15, the register write, the compare flag, a fault mark and
// the halt mark.
// ----------------------------------------------------------------------------
// Usage:
// Instructions enter on in_valid/in_ready and results leave on
// out_valid/out_ready, one result item for each instruction item.
// The data base register is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the unit is idle, as the unit itself does
// not enforce this; it resets to 1000.
// An item is read from the register file at acceptance, executed in the
// following cycle and committed into the output register once that
// register is empty or being read. A load first reads the data memory
// into a further register and is committed from there.
// Non-load items can be accepted every cycle while the output is not
// stalled; a load holds off the input until its result is committed.
// After reset the data memory is cleared one word per cycle with in_ready
// low. A stalled output holds its result and the unit keeps one more item
// ready to commit behind it.
`default_nettype none

module arm_subset_execute_unit_top
    import aseu_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic        [BASE_W-1:0]   cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic        [3:0]          operation,
    input  wire logic        [RF_AW-1:0]    dest_reg,
    input  wire logic        [RF_AW-1:0]    first_reg,
    input  wire logic        [RF_AW-1:0]    second_reg,
    input  wire logic                       use_immediate,
    input  wire logic signed [DATA_W-1:0]   immediate,
    input  wire logic        [1:0]          address_mode,
    input  wire logic        [TARGET_W-1:0] branch_target,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed      [DATA_W-1:0]   next_pc,
    output logic                            reg_written,
    output logic             [RF_AW-1:0]    written_reg,
    output logic signed      [DATA_W-1:0]   written_value,
    output logic             [1:0]          compare_flag,
    output logic                            memory_fault,
    output logic                            halted
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [DATA_W-1:0] dmem [MEM_WORDS];

    logic                in_accept;
    logic                clearing_reg;
    logic                clearing_next;
    logic [AW-1:0]       clr_cnt_reg;
    logic [AW-1:0]       clr_cnt_next;
    logic [BASE_W-1:0]   data_base_reg;
    logic [DATA_W-1:0]   pc_reg;
    logic [DATA_W-1:0]   pc_next;
    logic [1:0]          flag_reg;
    logic [1:0]          flag_next;
    logic                halt_reg;
    logic                halt_next;

    logic                e_valid_reg;
    logic                e_valid_next;
    logic [3:0]          e_op_reg;
    logic [RF_AW-1:0]    e_d_reg;
    logic [RF_AW-1:0]    e_a_reg;
    logic [RF_AW-1:0]    e_xaddr_reg;
    logic [RF_AW-1:0]    e_yaddr_reg;
    logic                e_useimm_reg;
    logic [DATA_W-1:0]   e_imm_reg;
    logic [1:0]          e_mode_reg;
    logic [TARGET_W-1:0] e_target_reg;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [RF_AW-1:0]    m_d_reg;
    logic [RF_AW-1:0]    m_a_reg;
    logic                m_post_reg;
    logic [DATA_W-1:0]   m_imm_reg;
    logic [DATA_W-1:0]   m_base_wb_reg;
    logic [DATA_W-1:0]   dm_rdata_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                o_wr_reg;
    logic [RF_AW-1:0]    o_wreg_reg;
    logic [DATA_W-1:0]   o_wval_reg;
    logic                o_fault_reg;

    logic [RF_AW-1:0]    rd_addr_x;
    logic [RF_AW-1:0]    rd_addr_y;
    logic [DATA_W-1:0]   rd_data_x;
    logic [DATA_W-1:0]   rd_data_y;
    rf_wr_t              rf_wr;

    logic [DATA_W-1:0]   reg_x;
    logic [DATA_W-1:0]   reg_y;
    logic [DATA_W-1:0]   opnd;
    logic [DATA_W-1:0]   prod;
    logic [DATA_W-1:0]   base_wb;
    logic [DATA_W-1:0]   off;
    logic                addr_bad;
    logic [AW-1:0]       e_idx;
    logic                e_is_mem;
    logic                e_go_m;
    logic                e_commit;
    logic                m_commit;
    logic                e_wr;
    logic [RF_AW-1:0]    e_wreg;
    logic [DATA_W-1:0]   e_wval;
    logic                e_branch;
    logic                e_fault;
    logic                e_store;
    logic [DATA_W-1:0]   m_wval;
    logic                dm_we;
    logic [AW-1:0]       dm_addr;
    logic [DATA_W-1:0]   dm_wdata;

    aseu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rf_wr),
        .rd_en     (in_accept),
        .rd_addr_x (rd_addr_x),
        .rd_addr_y (rd_addr_y),
        .rd_data_x (rd_data_x),
        .rd_data_y (rd_data_y)
    );

    assign rd_addr_x = (operation == OP_CMP) ? dest_reg : first_reg;
    assign rd_addr_y = (operation == OP_STR) ? dest_reg : second_reg;

    assign m_commit  = m_valid_reg && (!out_valid_reg || out_ready);
    assign e_commit  = e_valid_reg && !e_go_m && (!out_valid_reg || out_ready);
    assign in_ready  = !clearing_reg && !m_valid_reg && (!e_valid_reg || e_commit);
    assign in_accept = in_valid && in_ready;

    // Execute stage operands; r15 lives in its own register.
    assign reg_x    = (e_xaddr_reg == REG_PC) ? pc_reg : rd_data_x;
    assign reg_y    = (e_yaddr_reg == REG_PC) ? pc_reg : rd_data_y;
    assign opnd     = e_useimm_reg ? e_imm_reg : reg_y;
    assign prod     = reg_x * opnd;
    assign base_wb  = reg_x + e_imm_reg;
    assign off      = reg_x - {{(DATA_W-BASE_W){1'b0}}, data_base_reg}
                      + ((e_mode_reg == AMODE_OFFS) ? e_imm_reg : '0);
    assign addr_bad = off[DATA_W-1] || off[1] || off[0]
                      || (off[DATA_W-1:2] >= (DATA_W-2)'(MEM_WORDS));
    assign e_idx    = off[AW+1:2];
    assign e_is_mem = (e_op_reg == OP_LDR) || (e_op_reg == OP_STR);
    assign e_go_m   = e_valid_reg && !halt_reg && (e_op_reg == OP_LDR) && !addr_bad;
    assign e_fault  = !halt_reg && e_is_mem && addr_bad;
    assign e_store  = !halt_reg && (e_op_reg == OP_STR) && !addr_bad;

    always_comb
    begin
        e_wr      = 1'b0;
        e_wreg    = '0;
        e_wval    = '0;
        e_branch  = 1'b0;
        flag_next = flag_reg;
        if (!halt_reg)
        begin
            case (e_op_reg)
                OP_MOV:
                begin
                    e_wr   = 1'b1;
                    e_wreg = e_d_reg;
                    e_wval = opnd;
                end
                OP_CMP:
                begin
                    if ($signed(reg_x) > $signed(opnd))
                    begin
                        flag_next = FLAG_GT;
                    end
                    else if ($signed(reg_x) < $signed(opnd))
                    begin
                        flag_next = FLAG_LT;
                    end
                    else
                    begin
                        flag_next = FLAG_EQ;
                    end
                end
                OP_ADD:
                begin
                    e_wr   = 1'b1;
                    e_wreg = e_d_reg;
                    e_wval = reg_x + opnd;
                end
                OP_SUB:
                begin
                    e_wr   = 1'b1;
                    e_wreg = e_d_reg;
                    e_wval = reg_x - opnd;
                end
                OP_MUL:
                begin
                    e_wr   = 1'b1;
                    e_wreg = e_d_reg;
                    e_wval = prod;
                end
                OP_STR:
                begin
                    if (!addr_bad && (e_mode_reg == AMODE_POST))
                    begin
                        e_wr   = 1'b1;
                        e_wreg = e_a_reg;
                        e_wval = base_wb;
                    end
                end
                OP_LDRL:
                begin
                    e_wr   = 1'b1;
                    e_wreg = e_d_reg;
                    e_wval = {{(DATA_W-BASE_W){1'b0}}, data_base_reg};
                end
                OP_B:
                begin
                    e_branch = 1'b1;
                end
                OP_BNE:
                begin
                    e_branch = (flag_reg != FLAG_EQ);
                end
                OP_BGE:
                begin
                    e_branch = (flag_reg == FLAG_EQ) || (flag_reg == FLAG_GT);
                end
                OP_BL:
                begin
                    e_wr     = 1'b1;
                    e_wreg   = REG_LINK;
                    e_wval   = pc_reg;
                    e_branch = 1'b1;
                end
                default:
                begin
                    e_wr = 1'b0;
                end
            endcase
        end
    end

    assign m_wval = (m_post_reg && (m_a_reg == m_d_reg)) ? dm_rdata_reg + m_imm_reg
                                                         : dm_rdata_reg;

    always_comb
    begin
        rf_wr = '0;
        if (m_commit)
        begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = m_d_reg;
            rf_wr.data = m_wval;
        end
        else if (e_commit && e_wr)
        begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = e_wreg;
            rf_wr.data = e_wval;
        end
        else if (e_go_m && (e_mode_reg == AMODE_POST))
        begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = e_a_reg;
            rf_wr.data = base_wb;
        end
    end

    always_comb
    begin
        pc_next   = pc_reg;
        halt_next = halt_reg;
        if (m_commit)
        begin
            if (m_d_reg == REG_PC)
            begin
                pc_next = m_wval + 1'b1;
            end
            else if (m_post_reg && (m_a_reg == REG_PC))
            begin
                pc_next = m_base_wb_reg + 1'b1;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
        else if (e_commit && !halt_reg)
        begin
            if (e_op_reg == OP_EXIT)
            begin
                halt_next = 1'b1;
            end
            else if (e_branch)
            begin
                pc_next = {{(DATA_W-TARGET_W){1'b0}}, e_target_reg};
            end
            else if (e_wr && (e_wreg == REG_PC))
            begin
                pc_next = e_wval + 1'b1;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(MEM_WORDS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    assign dm_we    = clearing_reg || (e_commit && e_store);
    assign dm_addr  = clearing_reg ? clr_cnt_reg : e_idx;
    assign dm_wdata = clearing_reg ? '0 : reg_y;

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_addr] <= dm_wdata;
        end
        if (e_go_m)
        begin
            dm_rdata_reg <= dmem[e_idx];
        end
    end

    always_comb
    begin
        e_valid_next = e_valid_reg;
        if (in_accept)
        begin
            e_valid_next = 1'b1;
        end
        else if (e_commit || e_go_m)
        begin
            e_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (e_go_m)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_commit)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (e_commit || m_commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            data_base_reg <= DATA_BASE_RST;
            pc_reg        <= '0;
            flag_reg      <= FLAG_EQ;
            halt_reg      <= 1'b0;
            e_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                data_base_reg <= cfg_wr_data;
            end
            pc_reg        <= pc_next;
            if (e_commit)
            begin
                flag_reg <= flag_next;
            end
            halt_reg      <= halt_next;
            e_valid_reg   <= e_valid_next;
            m_valid_reg   <= m_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e_op_reg     <= operation;
            e_d_reg      <= dest_reg;
            e_a_reg      <= first_reg;
            e_xaddr_reg  <= rd_addr_x;
            e_yaddr_reg  <= rd_addr_y;
            e_useimm_reg <= use_immediate;
            e_imm_reg    <= immediate;
            e_mode_reg   <= address_mode;
            e_target_reg <= branch_target;
        end
        if (e_go_m)
        begin
            m_d_reg       <= e_d_reg;
            m_a_reg       <= e_a_reg;
            m_post_reg    <= (e_mode_reg == AMODE_POST);
            m_imm_reg     <= e_imm_reg;
            m_base_wb_reg <= base_wb;
        end
        if (m_commit)
        begin
            o_wr_reg    <= 1'b1;
            o_wreg_reg  <= m_d_reg;
            o_wval_reg  <= m_wval;
            o_fault_reg <= 1'b0;
        end
        else if (e_commit)
        begin
            o_wr_reg    <= e_wr;
            o_wreg_reg  <= e_wreg;
            o_wval_reg  <= e_wval;
            o_fault_reg <= e_fault;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = pc_reg;
    assign reg_written   = o_wr_reg;
    assign written_reg   = o_wreg_reg;
    assign written_value = o_wval_reg;
    assign compare_flag  = flag_reg;
    assign memory_fault  = o_fault_reg;
    assign halted        = halt_reg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench of arm_subset_execute_unit_top
// Drives decoded instructions through the valid/ready input channel and
// compares every result item with the fixed outcome of its directed row or,
// if none, with what a behavioral model of the unit predicts. A directed table
// comes first, then random phases under several data base settings, and an exit with items after it.
// ----------------------------------------------------------------------------
module tb
    import aseu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MEM_WORDS      = MEM_WORDS_DEF;
    localparam int          ITEMS_PER_SET  = 290;
    localparam int          NUM_SETS       = 5;
    localparam int          IDLE_PERCENT   = 12;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SHOWN_ERRORS   = 10;
    localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;
    localparam logic [1:0]  AMODE_SPARE    = 2'd3;

    typedef struct packed {
        logic [3:0]        op;
        logic [RF_AW-1:0]  rd;
        logic [RF_AW-1:0]  rn;
        logic [RF_AW-1:0]  rm;
        logic              ui;
        logic [DATA_W-1:0] imm;
        logic [1:0]        mode;
        logic [TARGET_W-1:0] tgt;
    } instr_t;

    typedef struct packed {
        logic [DATA_W-1:0] pc;
        logic              wr;
        logic [RF_AW-1:0]  wreg;
        logic [DATA_W-1:0] wval;
        logic [1:0]        flag;
        logic              fault;
        logic              halt;
    } outcome_t;

    typedef struct packed {
        instr_t   ins;
        logic     has_fixed;
        outcome_t fixed;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n         = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic        [BASE_W-1:0]   cfg_wr_data   = '0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic        [3:0]          operation     = '0;
    logic        [RF_AW-1:0]    dest_reg      = '0;
    logic        [RF_AW-1:0]    first_reg     = '0;
    logic        [RF_AW-1:0]    second_reg    = '0;
    logic                       use_immediate = 1'b0;
    logic signed [DATA_W-1:0]   immediate     = '0;
    logic        [1:0]          address_mode  = '0;
    logic        [TARGET_W-1:0] branch_target = '0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic signed [DATA_W-1:0]   next_pc;
    logic                       reg_written;
    logic        [RF_AW-1:0]    written_reg;
    logic signed [DATA_W-1:0]   written_value;
    logic        [1:0]          compare_flag;
    logic                       memory_fault;
    logic                       halted;

    logic [DATA_W-1:0] arch_regs [RF_DEPTH];
    logic [DATA_W-1:0] data_words [MEM_WORDS];
    logic [1:0]        cmp_flag;
    logic              halt_seen;
    logic [BASE_W-1:0] base_addr;

    outcome_t  pending_results [$];
    stim_row_t directed_rows [$];
    int        err_count   = 0;
    int        idle_cycles = 0;
    bit        calm        = 1'b0;
    outcome_t  seen_res;
    outcome_t  want_res;

    arm_subset_execute_unit_top #(
        .MEM_WORDS(MEM_WORDS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .dest_reg     (dest_reg),
        .first_reg    (first_reg),
        .second_reg   (second_reg),
        .use_immediate(use_immediate),
        .immediate    (immediate),
        .address_mode (address_mode),
        .branch_target(branch_target),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_pc      (next_pc),
        .reg_written  (reg_written),
        .written_reg  (written_reg),
        .written_value(written_value),
        .compare_flag (compare_flag),
        .memory_fault (memory_fault),
        .halted       (halted)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic instr_t instr(input logic [3:0] op, input logic [RF_AW-1:0] rd,
                                     input logic [RF_AW-1:0] rn, input logic [RF_AW-1:0] rm,
                                     input logic ui, input logic [DATA_W-1:0] imm,
                                     input logic [1:0] mode, input logic [TARGET_W-1:0] tgt);
        instr_t ins;
        ins.op   = op;
        ins.rd   = rd;
        ins.rn   = rn;
        ins.rm   = rm;
        ins.ui   = ui;
        ins.imm  = imm;
        ins.mode = mode;
        ins.tgt  = tgt;
        return ins;
    endfunction

    function automatic outcome_t outcome(input logic [DATA_W-1:0] pc, input logic wr,
                                         input logic [RF_AW-1:0] wreg,
                                         input logic [DATA_W-1:0] wval,
                                         input logic [1:0] flag, input logic fault);
        outcome_t res;
        res.pc    = pc;
        res.wr    = wr;
        res.wreg  = wreg;
        res.wval  = wval;
        res.flag  = flag;
        res.fault = fault;
        res.halt  = 1'b0;
        return res;
    endfunction

    task automatic add_row(input instr_t ins, input logic has_fixed, input outcome_t fixed);
        stim_row_t row;
        row.ins       = ins;
        row.has_fixed = has_fixed;
        row.fixed     = fixed;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic execute_instr(input instr_t ins, output outcome_t res);
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] opnd;
        logic [DATA_W-1:0] off;
        logic              branch;
        int unsigned       idx;
        res    = '0;
        pc     = arch_regs[REG_PC];
        opnd   = ins.ui ? ins.imm : arch_regs[ins.rm];
        branch = 1'b0;
        if (!halt_seen)
        begin
            case (ins.op)
                OP_MOV:
                begin
                    arch_regs[ins.rd] = opnd;
                    res.wr = 1'b1;
                    res.wreg = ins.rd;
                end
                OP_CMP:
                begin
                    if ($signed(arch_regs[ins.rd]) > $signed(opnd))
                        cmp_flag = FLAG_GT;
                    else if ($signed(arch_regs[ins.rd]) < $signed(opnd))
                        cmp_flag = FLAG_LT;
                    else
                        cmp_flag = FLAG_EQ;
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (ins.op == OP_ADD)
                        arch_regs[ins.rd] = arch_regs[ins.rn] + opnd;
                    else if (ins.op == OP_SUB)
                        arch_regs[ins.rd] = arch_regs[ins.rn] - opnd;
                    else
                        arch_regs[ins.rd] = arch_regs[ins.rn] * opnd;
                    res.wr = 1'b1;
                    res.wreg = ins.rd;
                end
                OP_LDR, OP_STR:
                begin
                    off = arch_regs[ins.rn] - {16'd0, base_addr};
                    if (ins.mode == AMODE_OFFS)
                        off = off + ins.imm;
                    if (off[31] || off[1:0] != 2'b00 || off[31:2] >= MEM_WORDS)
                        res.fault = 1'b1;
                    else
                    begin
                        idx = 32'(off[31:2]);
                        if (ins.op == OP_LDR)
                        begin
                            arch_regs[ins.rd] = data_words[idx];
                            res.wr = 1'b1;
                            res.wreg = ins.rd;
                        end
                        else
                            data_words[idx] = arch_regs[ins.rd];
                        if (ins.mode == AMODE_POST)
                        begin
                            arch_regs[ins.rn] = arch_regs[ins.rn] + ins.imm;
                            if (ins.op == OP_STR)
                            begin
                                res.wr = 1'b1;
                                res.wreg = ins.rn;
                            end
                        end
                    end
                end
                OP_LDRL:
                begin
                    arch_regs[ins.rd] = {16'd0, base_addr};
                    res.wr = 1'b1;
                    res.wreg = ins.rd;
                end
                OP_B:    branch = 1'b1;
                OP_BNE:  branch = (cmp_flag != FLAG_EQ);
                OP_BGE:  branch = (cmp_flag == FLAG_EQ || cmp_flag == FLAG_GT);
                OP_BL:
                begin
                    arch_regs[REG_LINK] = pc;
                    res.wr = 1'b1;
                    res.wreg = REG_LINK;
                    branch = 1'b1;
                end
                OP_EXIT: halt_seen = 1'b1;
                default: ;
            endcase
            if (res.wr)
                res.wval = arch_regs[res.wreg];
            if (ins.op != OP_EXIT)
                arch_regs[REG_PC] = branch ? {22'd0, ins.tgt} : arch_regs[REG_PC] + 1;
        end
        res.pc   = arch_regs[REG_PC];
        res.flag = cmp_flag;
        res.halt = halt_seen;
    endtask

    function automatic instr_t gen_instr();
        instr_t            ins;
        int unsigned       sel;
        logic [DATA_W-1:0] off;
        int                k;
        ins.op   = OP_MOV;
        ins.rd   = RF_AW'($urandom);
        ins.rn   = RF_AW'($urandom);
        ins.rm   = RF_AW'($urandom);
        ins.ui   = 1'($urandom);
        ins.mode = 2'($urandom);
        ins.tgt  = TARGET_W'($urandom);
        case ($urandom_range(0, 7))
            0:       ins.imm = 32'h7FFF_FFFF;
            1:       ins.imm = 32'h8000_0000;
            2:       ins.imm = 32'h0000_0000;
            3:       ins.imm = 32'hFFFF_FFFF;
            4:       ins.imm = 32'($urandom_range(0, 15));
            default: ins.imm = $urandom;
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            ins.op = 4'($urandom_range(0, 14));
            if (ins.op >= OP_EXIT)
                ins.op = ins.op + 4'd1;
            ins.imm = $urandom;
        end
        else if (sel < 45)
        begin
            ins.rn = RF_AW'($urandom_range(0, 13));
            off = arch_regs[ins.rn] - {16'd0, base_addr};
            if (off[31] || off[1:0] != 2'b00 || off[31:2] >= MEM_WORDS)
            begin
                ins.op  = OP_MOV;
                ins.rd  = ins.rn;
                ins.ui  = 1'b1;
                ins.imm = {16'd0, base_addr} + 32'(4 * $urandom_range(0, MEM_WORDS - 1));
            end
            else
            begin
                ins.op = $urandom_range(0, 1) ? OP_LDR : OP_STR;
                k = int'(off[31:2]);
                if ($urandom_range(0, 9) != 0)
                    ins.imm = 32'(4 * (int'($urandom_range(0, MEM_WORDS - 1)) - k));
                if ($urandom_range(0, 7) == 0)
                    ins.rd = ins.rn;
            end
        end
        else if (sel < 60)
        begin
            ins.op = OP_CMP;
            if ($urandom_range(0, 3) == 0)
            begin
                ins.ui = 1'b0;
                ins.rm = ins.rd;
            end
        end
        else if (sel < 75)
            ins.op = OP_B + 4'($urandom_range(0, 3));
        else
        begin
            case ($urandom_range(0, 4))
                0:       ins.op = OP_MOV;
                1:       ins.op = OP_ADD;
                2:       ins.op = OP_SUB;
                3:       ins.op = OP_MUL;
                default: ins.op = OP_LDRL;
            endcase
        end
        return ins;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= SHOWN_ERRORS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic send_instr(input instr_t ins, input logic has_fixed, input outcome_t fixed);
        outcome_t res;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation     <= ins.op;
        dest_reg      <= ins.rd;
        first_reg     <= ins.rn;
        second_reg    <= ins.rm;
        use_immediate <= ins.ui;
        immediate     <= ins.imm;
        address_mode  <= ins.mode;
        branch_target <= ins.tgt;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        execute_instr(ins, res);
        pending_results.insert(pending_results.size(), has_fixed ? fixed : res);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_data_base(input logic [BASE_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        base_addr = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_res.pc    = next_pc;
            seen_res.wr    = reg_written;
            seen_res.wreg  = written_reg;
            seen_res.wval  = written_value;
            seen_res.flag  = compare_flag;
            seen_res.fault = memory_fault;
            seen_res.halt  = halted;
            if (pending_results.size() == 0)
                note_error("result item with no expected item");
            else
            begin
                want_res = pending_results.pop_front();
                if (seen_res !== want_res)
                    note_error($sformatf({"mismatch: expected pc=%h wr=%b reg=%0d val=%h ",
                        "flag=%0d fault=%b halt=%b, actual pc=%h wr=%b reg=%0d val=%h ",
                        "flag=%0d fault=%b halt=%b"},
                        want_res.pc, want_res.wr, want_res.wreg, want_res.wval,
                        want_res.flag, want_res.fault, want_res.halt,
                        seen_res.pc, seen_res.wr, seen_res.wreg, seen_res.wval,
                        seen_res.flag, seen_res.fault, seen_res.halt));
            end
        end
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[arm_subset_execute_unit_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [BASE_W-1:0] set_base [NUM_SETS];

        foreach (arch_regs[i])
            arch_regs[i] = '0;
        foreach (data_words[i])
            data_words[i] = '0;
        cmp_flag  = FLAG_EQ;
        halt_seen = 1'b0;
        base_addr = DATA_BASE_RST;

        add_row(instr(OP_MOV, 1, 0, 0, 1, 32'h7FFF_FFFF, AMODE_BASE, 0), 1'b1,
                outcome(1, 1, 1, 32'h7FFF_FFFF, FLAG_EQ, 0));
        add_row(instr(OP_MOV, 2, 0, 0, 1, 32'h8000_0000, AMODE_BASE, 0), 1'b1,
                outcome(2, 1, 2, 32'h8000_0000, FLAG_EQ, 0));
        add_row(instr(OP_CMP, 1, 0, 2, 0, 0, AMODE_BASE, 0), 1'b1,
                outcome(3, 0, 0, 0, FLAG_GT, 0));
        add_row(instr(OP_ADD, 3, 1, 0, 1, 1, AMODE_BASE, 0), 1'b1,
                outcome(4, 1, 3, 32'h8000_0000, FLAG_GT, 0));
        add_row(instr(OP_SUB, 4, 2, 0, 1, 1, AMODE_BASE, 0), 1'b1,
                outcome(5, 1, 4, 32'h7FFF_FFFF, FLAG_GT, 0));
        add_row(instr(OP_MUL, 5, 1, 1, 0, 0, AMODE_BASE, 0), 1'b1,
                outcome(6, 1, 5, 1, FLAG_GT, 0));
        add_row(instr(OP_CMP, 2, 0, 0, 1, 0, AMODE_BASE, 0), 1'b1,
                outcome(7, 0, 0, 0, FLAG_LT, 0));
        add_row(instr(OP_LDRL, 6, 0, 0, 0, 0, AMODE_BASE, 0), 1'b1,
                outcome(8, 1, 6, 1000, FLAG_LT, 0));
        add_row(instr(OP_LDR, 7, 0, 0, 0, 0, AMODE_BASE, 0), 1'b1,
                outcome(9, 0, 0, 0, FLAG_LT, 1));
        add_row(instr(OP_STR, 1, 6, 0, 0, 0, AMODE_BASE, 0), 1'b0, '0);
        add_row(instr(OP_STR, 2, 6, 0, 0, 4, AMODE_POST, 0), 1'b0, '0);
        add_row(instr(OP_LDR, 6, 6, 0, 0, 8, AMODE_POST, 0), 1'b0, '0);
        add_row(instr(OP_LDRL, 10, 0, 0, 0, 0, AMODE_BASE, 0), 1'b0, '0);
        add_row(instr(OP_LDR, 11, 10, 0, 0, 2, AMODE_OFFS, 0), 1'b1,
                outcome(14, 0, 0, 0, FLAG_LT, 1));
        add_row(instr(OP_STR, 1, 10, 0, 0, 512, AMODE_OFFS, 0), 1'b1,
                outcome(15, 0, 0, 0, FLAG_LT, 1));
        add_row(instr(OP_STR, 1, 10, 0, 0, 508, AMODE_OFFS, 0), 1'b0, '0);
        add_row(instr(OP_LDR, 12, 10, 0, 0, 508, AMODE_SPARE, 0), 1'b0, '0);
        add_row(instr(OP_BGE, 0, 0, 0, 0, 0, AMODE_BASE, 40), 1'b0, '0);
        add_row(instr(OP_BNE, 0, 0, 0, 0, 0, AMODE_BASE, 2), 1'b0, '0);
        add_row(instr(OP_CMP, 1, 0, 4, 0, 0, AMODE_BASE, 0), 1'b0, '0);
        add_row(instr(OP_BNE, 0, 0, 0, 0, 0, AMODE_BASE, 100), 1'b0, '0);
        add_row(instr(OP_BGE, 0, 0, 0, 0, 0, AMODE_BASE, 1023), 1'b0, '0);
        add_row(instr(OP_CMP, 1, 0, 2, 0, 0, AMODE_BASE, 0), 1'b0, '0);
        add_row(instr(OP_BGE, 0, 0, 0, 0, 0, AMODE_BASE, 5), 1'b0, '0);
        add_row(instr(OP_B, 0, 0, 0, 0, 0, AMODE_BASE, 512), 1'b0, '0);
        add_row(instr(OP_BL, 0, 0, 0, 0, 0, AMODE_BASE, 7), 1'b0, '0);
        add_row(instr(OP_SPARE_LAST, 3, 3, 3, 1, 32'hFFFF_FFFF, AMODE_SPARE, 1023), 1'b0, '0);
        add_row(instr(OP_MOV, REG_PC, 0, 0, 1, 32'hFFFF_FFFF, AMODE_BASE, 0), 1'b0, '0);

        set_base[0] = 16'h0000;
        set_base[1] = 16'hFFFF;
        set_base[2] = BASE_W'($urandom);
        set_base[3] = DATA_BASE_RST;
        set_base[4] = BASE_W'($urandom);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_data_base(DATA_BASE_RST);

        foreach (directed_rows[i])
            send_instr(directed_rows[i].ins, directed_rows[i].has_fixed, directed_rows[i].fixed);
        drain();

        for (int s = 0; s < NUM_SETS; s++)
        begin
            set_data_base(set_base[s]);
            calm = (s == 2);
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_instr(gen_instr(), 1'b0, '0);
            drain();
        end
        calm = 1'b0;

        send_instr(instr(OP_EXIT, 0, 0, 0, 0, 0, AMODE_BASE, 0), 1'b0, '0);
        send_instr(instr(OP_MOV, 1, 0, 0, 1, 32'h1234_5678, AMODE_BASE, 0), 1'b0, '0);
        send_instr(instr(OP_B, 0, 0, 0, 0, 0, AMODE_BASE, 3), 1'b0, '0);
        drain();

        if (pending_results.size() != 0)
            note_error("expected result items left over at the end");
        if (err_count == 0)
            $display("[arm_subset_execute_unit_top] OK");
        else
            $display("[arm_subset_execute_unit_top] ERROR");
        $finish;
    end

endmodule
